/* hdl/gtds_pkg.sv */
`default_nettype none

package gtds_pkg;

    localparam int DEF_MAX_CATEGORIES  = 256;
    localparam int DEF_MAX_GUIDE_RATIO = 4;
    localparam int DEF_WEIGHT_BITS     = 32;

    localparam int N_USED_W  = 9;
    localparam int RATIO_W   = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_N_USED      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUIDE_RATIO = 1'd1;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT  = 2'd1;
    localparam logic [1:0] ST_ZERO_TOTAL = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  entry_index;
        logic [31:0] weight;
        logic [31:0] u_fraction;
    } item_t;

    typedef struct packed {
        logic [7:0] category;
        logic [1:0] status;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_G_RD,
        S_G_MUL,
        S_G_CMP,
        S_Q_SLOT,
        S_Q_GRD,
        S_Q_HI,
        S_Q_SUM,
        S_Q_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* hdl/guide_table_discrete_sampler_core.sv */
`default_nettype none

// Channel   Direction  Handshake            Word
// config    in         cfg_write            cfg_index, cfg_data
// request   in         in_valid / in_stall  req_type, entry_index, weight, u_fraction
// result    out        out_valid/out_stall  category, status
//
// A load, or a query before a build or with a zero total, goes straight to the result.
// A good query reads its guide slot, then walks down comparing one cumulative sum per step.
// A build accumulates the n weights into cumulative sums, then fills the m guide slots.
// The cumulative memory has a single registered read port, which sets the order of these steps.
// Reset clears the built flag and total; memories hold nothing useful until written.
// The result register frees the engine, so a new word is taken while a result is stalled.

module guide_table_discrete_sampler_core #(
    parameter int MAX_CATEGORIES  = gtds_pkg::DEF_MAX_CATEGORIES,
    parameter int MAX_GUIDE_RATIO = gtds_pkg::DEF_MAX_GUIDE_RATIO,
    parameter int WEIGHT_BITS     = gtds_pkg::DEF_WEIGHT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gtds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gtds_pkg::N_USED_W-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       req_type,
    input  logic [7:0]                       entry_index,
    input  logic [31:0]                      weight,
    input  logic [31:0]                      u_fraction,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       category,
    output logic [1:0]                       status
);

    import gtds_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CATEGORIES + 1);
    localparam int RAT_W  = $clog2(MAX_GUIDE_RATIO + 1);
    localparam int M_W    = $clog2(MAX_CATEGORIES * MAX_GUIDE_RATIO + 1);

    logic [CNT_W-1:0] n_reg, n_next;
    logic [RAT_W-1:0] ratio_reg, ratio_next;
    logic [M_W-1:0]   m_reg, m_next;
    logic [CNT_W-1:0] n_sat;
    logic [RAT_W-1:0] ratio_sat;

    logic    accept;
    logic    eng_idle;
    logic    eng_res_valid;
    logic    res_take;
    item_t   item;
    result_t eng_res;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    // Out-of-range settings saturate into range, zero counting as one; the ratio uses only the low RATIO_W bits.
    always_comb
    begin
        if (cfg_data == '0)
            n_sat = CNT_W'(1);
        else if (32'(cfg_data) > 32'(MAX_CATEGORIES))
            n_sat = CNT_W'(MAX_CATEGORIES);
        else
            n_sat = CNT_W'(cfg_data);

        if (cfg_data[RATIO_W-1:0] == '0)
            ratio_sat = RAT_W'(1);
        else if (32'(cfg_data[RATIO_W-1:0]) > 32'(MAX_GUIDE_RATIO))
            ratio_sat = RAT_W'(MAX_GUIDE_RATIO);
        else
            ratio_sat = RAT_W'(cfg_data[RATIO_W-1:0]);
    end

    always_comb
    begin
        n_next     = n_reg;
        ratio_next = ratio_reg;
        m_next     = m_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_N_USED:
                begin
                    n_next = n_sat;
                    m_next = M_W'(n_sat) * M_W'(ratio_reg);
                end
                CFG_GUIDE_RATIO:
                begin
                    ratio_next = ratio_sat;
                    m_next     = M_W'(n_reg) * M_W'(ratio_sat);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= CNT_W'(1);
            ratio_reg <= RAT_W'(1);
            m_reg     <= M_W'(1);
        end
        else
        begin
            n_reg     <= n_next;
            ratio_reg <= ratio_next;
            m_reg     <= m_next;
        end
    end

    assign in_stall = !eng_idle;
    assign accept   = in_valid && !in_stall;

    assign item.req_type    = req_type;
    assign item.entry_index = entry_index;
    assign item.weight      = weight;
    assign item.u_fraction  = u_fraction;

    gtds_engine #(
        .MAX_CATEGORIES  (MAX_CATEGORIES),
        .MAX_GUIDE_RATIO (MAX_GUIDE_RATIO),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .item      (item),
        .n_eff     (n_reg),
        .m_slots   (m_reg),
        .cfg_clear (cfg_write),
        .res_take  (res_take),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res       (eng_res)
    );

    assign res_take = eng_res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_res_reg <= eng_res;
    end

    assign out_valid = out_valid_reg;
    assign category  = out_res_reg.category;
    assign status    = out_res_reg.status;

endmodule

`default_nettype wire

/* hdl/gtds_engine.sv */
`default_nettype none

module gtds_engine #(
    parameter int MAX_CATEGORIES  = gtds_pkg::DEF_MAX_CATEGORIES,
    parameter int MAX_GUIDE_RATIO = gtds_pkg::DEF_MAX_GUIDE_RATIO,
    parameter int WEIGHT_BITS     = gtds_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   start,
    input  gtds_pkg::item_t                                        item,
    input  logic [$clog2(MAX_CATEGORIES+1)-1:0]                    n_eff,
    input  logic [$clog2(MAX_CATEGORIES*MAX_GUIDE_RATIO+1)-1:0]    m_slots,
    input  logic                                                   cfg_clear,
    input  logic                                                   res_take,
    output logic                                                   idle,
    output logic                                                   res_valid,
    output gtds_pkg::result_t                                      res
);

    import gtds_pkg::*;

    localparam int IDX_W   = $clog2(MAX_CATEGORIES);
    localparam int CNT_W   = $clog2(MAX_CATEGORIES + 1);
    localparam int GDEPTH  = MAX_CATEGORIES * MAX_GUIDE_RATIO;
    localparam int GIDX_W  = $clog2(GDEPTH);
    localparam int M_W     = $clog2(GDEPTH + 1);
    localparam int CUM_W   = WEIGHT_BITS + IDX_W;
    localparam int PROD_W  = CUM_W + M_W;
    localparam int SP_W    = 32 + M_W;
    localparam int XT_W    = CUM_W + 32;

    state_t state_reg, state_next;

    // Three single-port-per-direction memories with registered reads.
    logic [WEIGHT_BITS-1:0] weight_mem [MAX_CATEGORIES];
    logic [CUM_W-1:0]       cum_mem    [MAX_CATEGORIES];
    logic [IDX_W-1:0]       guide_mem  [GDEPTH];

    logic [WEIGHT_BITS-1:0] w_rd_reg;
    logic [CUM_W-1:0]       c_rd_reg;
    logic [IDX_W-1:0]       g_rd_reg;

    logic                   w_we, c_we, g_we;
    logic [IDX_W-1:0]       w_waddr, w_raddr, c_waddr, c_raddr;
    logic [WEIGHT_BITS-1:0] w_wdata;
    logic [CUM_W-1:0]       c_wdata;
    logic [GIDX_W-1:0]      g_waddr, g_raddr;
    logic [IDX_W-1:0]       g_wdata;

    logic              built_reg, built_next;
    logic [CUM_W-1:0]  total_reg, total_next;
    logic [CUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [M_W-1:0]    j_reg, j_next;
    logic [PROD_W-1:0] rhs_reg, rhs_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [31:0]       u_reg, u_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [63:0]       xlo_reg, xlo_next;
    logic [63:0]       xhi_reg, xhi_next;
    logic [XT_W-1:0]   xt_reg, xt_next;
    logic [IDX_W-1:0]  qi_reg, qi_next;
    result_t           res_reg, res_next;

    logic [CNT_W-1:0]  idx_inc;
    logic [CUM_W-1:0]  sum_acc;
    logic              acc_last;
    logic              g_adv;
    logic              g_last;
    logic              q_step;
    logic              q_go;
    logic              load_in_range;
    logic [M_W-1:0]    slot_raw;
    logic [M_W-1:0]    slot_clip;
    logic [63:0]       t64;
    logic [95:0]       xt_full;
    logic [IDX_W-1:0]  cat_val;

    assign idx_inc       = idx_reg + CNT_W'(1);
    assign sum_acc       = sum_reg + CUM_W'(w_rd_reg);
    assign acc_last      = (idx_inc == n_eff);
    assign g_adv         = (idx_inc < n_eff) && (prod_reg < rhs_reg);
    assign g_last        = ((j_reg + M_W'(1)) == m_slots);
    assign q_step        = ({c_rd_reg, 32'b0} > xt_reg);
    assign q_go          = built_reg && (total_reg != '0);
    assign load_in_range = (32'(item.entry_index) < 32'(MAX_CATEGORIES));
    assign slot_raw      = sp_reg[32 +: M_W];
    assign slot_clip     = (slot_raw >= m_slots) ? (m_slots - M_W'(1)) : slot_raw;
    assign t64           = 64'(total_reg);
    assign xt_full       = {xhi_reg, 32'b0} + {32'b0, xlo_reg};
    assign cat_val       = q_step ? (qi_reg - IDX_W'(1)) : qi_reg;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.req_type == REQ_BUILD)
                        state_next = S_ACC_RD;
                    else if (item.req_type == REQ_QUERY && q_go)
                        state_next = S_Q_SLOT;
                    else
                        state_next = S_DONE;
                end
            end
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR: state_next = acc_last ? S_G_RD : S_ACC_RD;
            S_G_RD:   state_next = S_G_MUL;
            S_G_MUL:  state_next = S_G_CMP;
            S_G_CMP:
            begin
                if (g_adv)
                    state_next = S_G_RD;
                else if (g_last)
                    state_next = S_DONE;
            end
            S_Q_SLOT: state_next = S_Q_GRD;
            S_Q_GRD:  state_next = S_Q_HI;
            S_Q_HI:   state_next = S_Q_SUM;
            S_Q_SUM:  state_next = (qi_reg == '0) ? S_DONE : S_Q_CMP;
            S_Q_CMP:
            begin
                if (!q_step || qi_reg == IDX_W'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        built_next = built_reg;
        total_next = total_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        rhs_next   = rhs_reg;
        prod_next  = prod_reg;
        u_next     = u_reg;
        sp_next    = sp_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        xt_next    = xt_reg;
        qi_next    = qi_reg;
        res_next   = res_reg;

        w_we    = 1'b0;
        w_waddr = IDX_W'(item.entry_index);
        w_wdata = WEIGHT_BITS'(item.weight);
        w_raddr = idx_reg[IDX_W-1:0];
        c_we    = 1'b0;
        c_waddr = idx_reg[IDX_W-1:0];
        c_wdata = sum_acc;
        c_raddr = idx_reg[IDX_W-1:0];
        g_we    = 1'b0;
        g_waddr = j_reg[GIDX_W-1:0];
        g_wdata = idx_reg[IDX_W-1:0];
        g_raddr = slot_clip[GIDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next.category = '0;
                    res_next.status   = ST_OK;
                    u_next            = item.u_fraction;
                    idx_next          = '0;
                    sum_next          = '0;
                    if (item.req_type == REQ_LOAD)
                    begin
                        w_we       = load_in_range;
                        built_next = 1'b0;
                    end
                    else if (item.req_type == REQ_QUERY)
                    begin
                        if (!built_reg)
                            res_next.status = ST_NOT_BUILT;
                        else if (total_reg == '0)
                            res_next.status = ST_ZERO_TOTAL;
                    end
                end
            end
            S_ACC_RD:
            begin
                w_raddr = idx_reg[IDX_W-1:0];
            end
            S_ACC_WR:
            begin
                c_we     = 1'b1;
                sum_next = sum_acc;
                idx_next = idx_inc;
                if (acc_last)
                begin
                    total_next = sum_acc;
                    idx_next   = '0;
                    j_next     = '0;
                    rhs_next   = PROD_W'(sum_acc);
                end
            end
            S_G_RD:
            begin
                c_raddr = idx_reg[IDX_W-1:0];
            end
            S_G_MUL:
            begin
                prod_next = PROD_W'(c_rd_reg) * PROD_W'(m_slots);
            end
            S_G_CMP:
            begin
                if (g_adv)
                    idx_next = idx_inc;
                else
                begin
                    g_we = 1'b1;
                    if (g_last)
                    begin
                        built_next      = 1'b1;
                        res_next.status = (total_reg == '0) ? ST_ZERO_TOTAL : ST_OK;
                    end
                    else
                    begin
                        // The same cumulative sum is tried against the next slot's bound.
                        j_next   = j_reg + M_W'(1);
                        rhs_next = rhs_reg + PROD_W'(total_reg);
                    end
                end
            end
            S_Q_SLOT:
            begin
                sp_next = SP_W'(u_reg) * SP_W'(m_slots);
            end
            S_Q_GRD:
            begin
                g_raddr  = slot_clip[GIDX_W-1:0];
                xlo_next = 64'(u_reg) * 64'(t64[31:0]);
            end
            S_Q_HI:
            begin
                qi_next  = g_rd_reg;
                xhi_next = 64'(u_reg) * 64'(t64[63:32]);
            end
            S_Q_SUM:
            begin
                xt_next = xt_full[XT_W-1:0];
                c_raddr = qi_reg - IDX_W'(1);
                if (qi_reg == '0)
                    res_next.category = '0;
            end
            S_Q_CMP:
            begin
                // Walk down one category per cycle; the next address is read ahead.
                c_raddr = qi_reg - IDX_W'(2);
                if (q_step)
                    qi_next = qi_reg - IDX_W'(1);
                res_next.category = 8'(cat_val);
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (cfg_clear)
            built_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            built_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        idx_reg  <= idx_next;
        j_reg    <= j_next;
        rhs_reg  <= rhs_next;
        prod_reg <= prod_next;
        u_reg    <= u_next;
        sp_reg   <= sp_next;
        xlo_reg  <= xlo_next;
        xhi_reg  <= xhi_next;
        xt_reg   <= xt_next;
        qi_reg   <= qi_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            weight_mem[w_waddr] <= w_wdata;
        w_rd_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            cum_mem[c_waddr] <= c_wdata;
        c_rd_reg <= cum_mem[c_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            guide_mem[g_waddr] <= g_wdata;
        g_rd_reg <= guide_mem[g_raddr];
    end

endmodule

`default_nettype wire
